// File: rtl/i2cme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cme_pkg - shared types and constants of the I2C master byte engine
// Command codes, decoded command item, result word, phase encoding and the
// segment length table of the bit timing sequencer.
// ----------------------------------------------------------------------------
package i2cme_pkg;

	// Command codes carried in the opcode field
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_UNIT_TICKS = 1'b0;
	localparam logic CFG_ACK_POLL   = 1'b1;

	// Register reset values
	localparam logic [15:0] UNIT_TICKS_RESET = 16'd72;
	localparam logic [7:0]  ACK_POLL_RESET   = 8'd250;

	// Default depth of the command queue between decode and sequencer
	localparam int QUEUE_DEPTH = 4;

	// One tick after decode: a classified command plus the sampled SDA line
	typedef struct packed {
		logic       is_start;
		logic       is_stop;
		logic       is_write;
		logic       is_read;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} item_t;

	// One result tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} result_t;

	// Queue status seen by the front end and the checks
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Sequencer phases
	typedef enum logic [15:0] {
		PH_IDLE   = 16'h0001,
		PH_ST_A   = 16'h0002,
		PH_ST_B   = 16'h0004,
		PH_SP_A   = 16'h0008,
		PH_SP_B   = 16'h0010,
		PH_SP_C   = 16'h0020,
		PH_W_SET  = 16'h0040,
		PH_W_HI   = 16'h0080,
		PH_W_LO   = 16'h0100,
		PH_K_REL  = 16'h0200,
		PH_K_RISE = 16'h0400,
		PH_K_POLL = 16'h0800,
		PH_R_LO   = 16'h1000,
		PH_R_HI   = 16'h2000,
		PH_A_SET  = 16'h4000,
		PH_A_HI   = 16'h8000
	} phase_t;

	// Segment length in delay units; zero for phases without a timer
	function automatic logic [2:0] seg_units(input phase_t ph);
		logic [2:0] len;
		unique case (ph)
			PH_ST_A, PH_ST_B:                      len = 3'd5;
			PH_SP_A, PH_SP_C:                      len = 3'd4;
			PH_W_SET, PH_W_HI, PH_W_LO:            len = 3'd2;
			PH_R_LO, PH_A_SET, PH_A_HI:            len = 3'd2;
			PH_K_REL, PH_K_RISE, PH_R_HI:          len = 3'd1;
			default:                               len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

// File: rtl/i2cme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cme_front - input stage of the I2C master byte engine
// Accepts one tick per transaction, decodes the opcode into a one-hot
// command kind and hands the item to the command queue.
// ----------------------------------------------------------------------------
module i2cme_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd_valid,
	input  logic [1:0]           opcode,
	input  logic [7:0]           tx_byte,
	input  logic                 send_ack,
	input  logic                 sda_in,
	input  i2cme_pkg::qstat_t    qstat,
	output logic                 push,
	output i2cme_pkg::item_t     push_item
);

	logic             valid_s1;
	i2cme_pkg::item_t item_s1;
	i2cme_pkg::item_t decoded;

	// Classify the command of this tick
	always_comb begin
		decoded          = '0;
		decoded.tx_byte  = tx_byte;
		decoded.send_ack = send_ack;
		decoded.sda_in   = sda_in;
		unique case (opcode)
			i2cme_pkg::OP_START: decoded.is_start = cmd_valid;
			i2cme_pkg::OP_STOP:  decoded.is_stop  = cmd_valid;
			i2cme_pkg::OP_WRITE: decoded.is_write = cmd_valid;
			i2cme_pkg::OP_READ:  decoded.is_read  = cmd_valid;
			default:             decoded.is_start = 1'b0;
		endcase
	end

	// Forward to the queue; stall only when the queue is full
	assign push     = valid_s1 && !qstat.full;
	assign in_ready = !valid_s1 || !qstat.full;

	// Hold the decoded tick until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= decoded;
		end
	end

	assign push_item = item_s1;

endmodule

// File: rtl/i2cme_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cme_queue - command queue between decode and sequencer
// Small circular buffer of decoded ticks; lets each side stall on its own.
// ----------------------------------------------------------------------------
module i2cme_queue #(
	parameter int DEPTH = i2cme_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i2cme_pkg::item_t     push_item,
	input  logic                 pop_ready,
	output logic                 pop_valid,
	output i2cme_pkg::item_t     pop_item,
	output i2cme_pkg::qstat_t    qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	i2cme_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_valid   = !qstat.empty;
	assign pop_item    = mem_q[rd_ptr_q];
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop_ready && !qstat.empty;

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/i2cme_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cme_back - bit timing sequencer of the I2C master byte engine
// Runs one tick per queued item through the start, stop, write and read
// sequences and registers the line levels and status as the result.
// ----------------------------------------------------------------------------
module i2cme_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          unit_ticks,
	input  logic [7:0]           ack_poll_limit,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  i2cme_pkg::item_t     item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output i2cme_pkg::result_t   res
);

	i2cme_pkg::phase_t phase_q, n_phase;
	logic [15:0] dc_q, n_dc, tmr_dc, dc_inc, unit_eff;
	logic [2:0]  uc_q, n_uc, tmr_uc, uc_inc, seg_len;
	logic [3:0]  bit_q, n_bit, bit_inc;
	logic [7:0]  shift_q, n_shift, rd_shift;
	logic [7:0]  poll_q, n_poll;
	logic        scl_q, n_scl, sda_q, n_sda;
	logic        ack_q, n_ack, fail_q, n_fail;
	logic [7:0]  rx_q, n_rx;
	logic        n_done, expired, take, res_valid_q;
	i2cme_pkg::result_t res_q;

	assign take       = item_valid && item_ready;
	assign item_ready = !res_valid_q || res_ready;

	// Segment timer: ticks per unit, units per segment
	always_comb begin
		unit_eff = (unit_ticks == '0) ? 16'd1 : unit_ticks;
		seg_len  = i2cme_pkg::seg_units(phase_q);
		dc_inc   = dc_q + 16'd1;
		uc_inc   = uc_q + 3'd1;
		expired  = 1'b0;
		tmr_dc   = dc_inc;
		tmr_uc   = uc_q;
		if (dc_inc >= unit_eff) begin
			tmr_dc = '0;
			tmr_uc = uc_inc;
			if (uc_inc >= seg_len) begin
				tmr_uc  = '0;
				expired = 1'b1;
			end
		end
	end

	assign bit_inc  = bit_q + 4'd1;
	assign rd_shift = {shift_q[6:0], item.sda_in};

	// Next state of the sequencer for one tick
	always_comb begin
		n_phase = phase_q;
		n_dc    = dc_q;
		n_uc    = uc_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_poll  = poll_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		n_fail  = fail_q;
		n_rx    = rx_q;
		n_done  = 1'b0;
		unique case (phase_q)
			i2cme_pkg::PH_IDLE: begin
				n_dc = '0;
				n_uc = '0;
				if (item.is_start) begin
					n_scl   = 1'b1;
					n_sda   = 1'b1;
					n_phase = i2cme_pkg::PH_ST_A;
				end else if (item.is_stop) begin
					n_scl   = 1'b0;
					n_sda   = 1'b0;
					n_phase = i2cme_pkg::PH_SP_A;
				end else if (item.is_write) begin
					n_fail  = 1'b0;
					n_shift = item.tx_byte;
					n_bit   = '0;
					n_scl   = 1'b0;
					n_sda   = item.tx_byte[7];
					n_phase = i2cme_pkg::PH_W_SET;
				end else if (item.is_read) begin
					n_shift = '0;
					n_bit   = '0;
					n_ack   = item.send_ack;
					n_scl   = 1'b0;
					n_sda   = 1'b1;
					n_phase = i2cme_pkg::PH_R_LO;
				end
			end
			i2cme_pkg::PH_SP_B: begin
				n_sda   = 1'b1;
				n_dc    = '0;
				n_uc    = '0;
				n_phase = i2cme_pkg::PH_SP_C;
			end
			i2cme_pkg::PH_K_POLL: begin
				if (!item.sda_in) begin
					// Acknowledge seen: pull SCL low and finish
					n_scl   = 1'b0;
					n_dc    = '0;
					n_uc    = '0;
					n_phase = i2cme_pkg::PH_IDLE;
					n_done  = 1'b1;
				end else if (poll_q >= ack_poll_limit) begin
					// Timeout: flag it and run the stop sequence
					n_fail  = 1'b1;
					n_scl   = 1'b0;
					n_sda   = 1'b0;
					n_dc    = '0;
					n_uc    = '0;
					n_phase = i2cme_pkg::PH_SP_A;
				end else begin
					n_poll = poll_q + 8'd1;
				end
			end
			default: begin
				n_dc = tmr_dc;
				n_uc = tmr_uc;
				if (expired) begin
					unique case (phase_q)
						i2cme_pkg::PH_ST_A: begin
							n_sda   = 1'b0;
							n_phase = i2cme_pkg::PH_ST_B;
						end
						i2cme_pkg::PH_ST_B: begin
							n_scl   = 1'b0;
							n_phase = i2cme_pkg::PH_IDLE;
							n_done  = 1'b1;
						end
						i2cme_pkg::PH_SP_A: begin
							n_scl   = 1'b1;
							n_phase = i2cme_pkg::PH_SP_B;
						end
						i2cme_pkg::PH_SP_C: begin
							n_phase = i2cme_pkg::PH_IDLE;
							n_done  = 1'b1;
						end
						i2cme_pkg::PH_W_SET: begin
							n_scl   = 1'b1;
							n_phase = i2cme_pkg::PH_W_HI;
						end
						i2cme_pkg::PH_W_HI: begin
							n_scl   = 1'b0;
							n_phase = i2cme_pkg::PH_W_LO;
						end
						i2cme_pkg::PH_W_LO: begin
							n_bit = bit_inc;
							if (bit_inc < 4'd8) begin
								n_shift = {shift_q[6:0], 1'b0};
								n_sda   = shift_q[6];
								n_phase = i2cme_pkg::PH_W_SET;
							end else begin
								n_sda   = 1'b1;
								n_phase = i2cme_pkg::PH_K_REL;
							end
						end
						i2cme_pkg::PH_K_REL: begin
							n_scl   = 1'b1;
							n_phase = i2cme_pkg::PH_K_RISE;
						end
						i2cme_pkg::PH_K_RISE: begin
							n_poll  = '0;
							n_phase = i2cme_pkg::PH_K_POLL;
						end
						i2cme_pkg::PH_R_LO: begin
							n_scl   = 1'b1;
							n_phase = i2cme_pkg::PH_R_HI;
						end
						i2cme_pkg::PH_R_HI: begin
							// Sample SDA at the end of the high segment
							n_shift = rd_shift;
							n_scl   = 1'b0;
							n_bit   = bit_inc;
							if (bit_inc < 4'd8) begin
								n_phase = i2cme_pkg::PH_R_LO;
							end else begin
								n_rx    = rd_shift;
								n_sda   = !ack_q;
								n_phase = i2cme_pkg::PH_A_SET;
							end
						end
						i2cme_pkg::PH_A_SET: begin
							n_scl   = 1'b1;
							n_phase = i2cme_pkg::PH_A_HI;
						end
						i2cme_pkg::PH_A_HI: begin
							n_scl   = 1'b0;
							n_phase = i2cme_pkg::PH_IDLE;
							n_done  = 1'b1;
						end
						default: begin
							n_phase = i2cme_pkg::PH_IDLE;
						end
					endcase
				end
			end
		endcase
	end

	// Commit the tick and register its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cme_pkg::PH_IDLE;
			dc_q        <= '0;
			uc_q        <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			ack_q       <= 1'b0;
			fail_q      <= 1'b0;
			rx_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= n_phase;
				dc_q    <= n_dc;
				uc_q    <= n_uc;
				bit_q   <= n_bit;
				shift_q <= n_shift;
				poll_q  <= n_poll;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				ack_q   <= n_ack;
				fail_q  <= n_fail;
				rx_q    <= n_rx;
			end
			if (item_ready) begin
				res_valid_q <= item_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.scl_level  <= n_scl;
			res_q.sda_level  <= n_sda;
			res_q.busy_res   <= (n_phase != i2cme_pkg::PH_IDLE);
			res_q.done_res   <= n_done;
			res_q.rx_byte    <= n_rx;
			res_q.ack_failed <= n_fail;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine - bit-level I2C master with byte commands
// Each stream transaction is one tick of the bit timer; each tick yields
// one result transaction with the SCL/SDA line levels and status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per transaction: tuser is the opcode (start,
//   stop, write, read); tdata holds the command-valid flag, the byte to
//   write, the ACK choice for reads and the sampled SDA level.
//   m_axis returns one result per tick, in order: SCL and SDA levels
//   (1 = released), busy, a one-tick done pulse, the last read byte and
//   the acknowledge-failed flag. Drive the open-drain pads from the levels.
//   cfg writes unit_ticks (index 0) and ack_poll_limit (index 1); write
//   only while no ticks are in flight. cfg_ready is always high.
// Throughput: one tick per cycle while neither stream stalls. Each tick
//   passes the decode register, the queue and the sequencer output register.
// Reset: both lines driven low, sequencer idle, registers back to 72 and
//   250, queue empty.
// Stalls: when m_axis_tready is low the result register holds; the queue
//   absorbs ticks until full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine #(
	parameter int QUEUE_DEPTH = i2cme_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: cmd_valid[0], tx_byte[8:1], send_ack[9], sda_in[10], zero[15:11]
	input  logic [15:0] s_axis_tdata,
	// tuser: opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: scl_level[0], sda_level[1], busy_res[2], done_res[3],
	//        rx_byte[11:4], ack_failed[12], zero[15:13]
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]        unit_ticks_q;
	logic [7:0]         ack_poll_q;
	logic               push;
	i2cme_pkg::item_t   push_item;
	i2cme_pkg::qstat_t  qstat;
	logic               pop_valid;
	logic               pop_ready;
	i2cme_pkg::item_t   pop_item;
	i2cme_pkg::result_t res;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= i2cme_pkg::UNIT_TICKS_RESET;
			ack_poll_q   <= i2cme_pkg::ACK_POLL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				i2cme_pkg::CFG_UNIT_TICKS: unit_ticks_q <= cfg_data;
				i2cme_pkg::CFG_ACK_POLL:   ack_poll_q   <= cfg_data[7:0];
				default:                   ack_poll_q   <= ack_poll_q;
			endcase
		end
	end

	i2cme_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd_valid (s_axis_tdata[0]),
		.opcode    (s_axis_tuser),
		.tx_byte   (s_axis_tdata[8:1]),
		.send_ack  (s_axis_tdata[9]),
		.sda_in    (s_axis_tdata[10]),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	i2cme_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop_ready (pop_ready),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	i2cme_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.unit_ticks     (unit_ticks_q),
		.ack_poll_limit (ack_poll_q),
		.item_valid     (pop_valid),
		.item_ready     (pop_ready),
		.item           (pop_item),
		.res_valid      (m_axis_tvalid),
		.res_ready      (m_axis_tready),
		.res            (res)
	);

	// Pack the result word
	assign m_axis_tdata = {3'b000, res.ack_failed, res.rx_byte, res.done_res,
		res.busy_res, res.sda_level, res.scl_level};

	// A completed command always leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.done_res) |-> !res.busy_res)
		else $error("done pulse while still busy");

	// The input side only stalls behind a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> qstat.full)
		else $error("input stalled with room in the queue");

	// A stalled result leaves the queue untouched
	a_hold_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !pop_ready)
		else $error("sequencer advanced behind a stalled result");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - self-checking bench for the I2C master byte engine
// Sends one bit-timer tick per input transaction and predicts every result
// transaction with a tick-exact model of the sequencer kept in a scoreboard.
// Line levels and status are compared field by field. A directed pass walks
// the commands, the timing extremes and the acknowledge cases; random command
// streams then run under several unit and poll-limit settings, with bursty
// input and a result side that stalls, once for a long stretch.
// ---------------------------------------------------------------------------
module tb;

	localparam int RANDOM_TICKS  = 500;
	localparam int RANDOM_PHASES = 5;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AFTER    = 800;
	localparam int PRINT_LIMIT   = 50;

	// How the bus answers during the acknowledge wait
	localparam int ACK_NOW   = 0;
	localparam int ACK_LATER = 1;
	localparam int ACK_NEVER = 2;

	// One tick as offered on the input stream
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] opcode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_t;

	// Line sequencer model plus the queue of results it predicts
	class i2c_tick_scoreboard;
		logic [15:0]         unit_ticks;
		logic [7:0]          poll_limit;
		i2cme_pkg::phase_t   phase;
		logic [15:0]         delay_count;
		logic [2:0]          unit_count;
		logic [3:0]          bit_index;
		logic [7:0]          shift_byte;
		logic [7:0]          poll_count;
		logic                scl;
		logic                sda;
		logic                ack_choice;
		logic                fail_flag;
		logic [7:0]          rx_hold;
		i2cme_pkg::result_t  expected_q[$];
		int                  checked;
		int                  cmd_count[4];
		int                  ignored;
		int                  timeouts;

		function new();
			unit_ticks = i2cme_pkg::UNIT_TICKS_RESET;
			poll_limit = i2cme_pkg::ACK_POLL_RESET;
			phase = i2cme_pkg::PH_IDLE;
			delay_count = '0;
			unit_count = '0;
			bit_index = '0;
			shift_byte = '0;
			poll_count = '0;
			scl = 1'b0;
			sda = 1'b0;
			ack_choice = 1'b0;
			fail_flag = 1'b0;
			rx_hold = '0;
			checked = 0;
			ignored = 0;
			timeouts = 0;
			foreach (cmd_count[i])
				cmd_count[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] value);
			if (idx == i2cme_pkg::CFG_UNIT_TICKS)
				unit_ticks = value;
			else
				poll_limit = value[7:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void enter(i2cme_pkg::phase_t ph);
			phase = ph;
			delay_count = '0;
			unit_count = '0;
		endfunction

		function void begin_stop();
			scl = 1'b0;
			sda = 1'b0;
			enter(i2cme_pkg::PH_SP_A);
		endfunction

		// Segment length in units for the timed phases
		function logic [2:0] seg_len(i2cme_pkg::phase_t ph);
			case (ph)
				i2cme_pkg::PH_ST_A, i2cme_pkg::PH_ST_B: return 3'd5;
				i2cme_pkg::PH_SP_A, i2cme_pkg::PH_SP_C: return 3'd4;
				i2cme_pkg::PH_K_REL, i2cme_pkg::PH_K_RISE,
				i2cme_pkg::PH_R_HI:                     return 3'd1;
				default:                                return 3'd2;
			endcase
		endfunction

		// Advance the segment timer; true when the segment is over
		function bit tick_timer(logic [2:0] len);
			logic [15:0] unit_len;
			unit_len = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
			delay_count = delay_count + 16'd1;
			if (delay_count >= unit_len) begin
				delay_count = '0;
				unit_count = unit_count + 3'd1;
				if (unit_count >= len) begin
					unit_count = '0;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Step the model by one accepted tick and queue the line state after it
		function void note_tick(tick_t t);
			i2cme_pkg::result_t r;
			logic               fin;
			fin = 1'b0;
			if (phase != i2cme_pkg::PH_IDLE && t.cmd_valid)
				ignored++;
			case (phase)
				i2cme_pkg::PH_IDLE: begin
					if (t.cmd_valid) begin
						cmd_count[t.opcode]++;
						case (t.opcode)
							i2cme_pkg::OP_START: begin
								scl = 1'b1;
								sda = 1'b1;
								enter(i2cme_pkg::PH_ST_A);
							end
							i2cme_pkg::OP_STOP: begin
								begin_stop();
							end
							i2cme_pkg::OP_WRITE: begin
								fail_flag = 1'b0;
								shift_byte = t.tx_byte;
								bit_index = '0;
								scl = 1'b0;
								sda = t.tx_byte[7];
								enter(i2cme_pkg::PH_W_SET);
							end
							default: begin
								shift_byte = '0;
								bit_index = '0;
								ack_choice = t.send_ack;
								scl = 1'b0;
								sda = 1'b1;
								enter(i2cme_pkg::PH_R_LO);
							end
						endcase
					end
				end
				i2cme_pkg::PH_SP_B: begin
					sda = 1'b1;
					enter(i2cme_pkg::PH_SP_C);
				end
				i2cme_pkg::PH_K_POLL: begin
					if (!t.sda_in) begin
						scl = 1'b0;
						enter(i2cme_pkg::PH_IDLE);
						fin = 1'b1;
					end else if (poll_count >= poll_limit) begin
						fail_flag = 1'b1;
						timeouts++;
						begin_stop();
					end else begin
						poll_count = poll_count + 8'd1;
					end
				end
				default: begin
					if (tick_timer(seg_len(phase))) begin
						case (phase)
							i2cme_pkg::PH_ST_A: begin
								sda = 1'b0;
								enter(i2cme_pkg::PH_ST_B);
							end
							i2cme_pkg::PH_ST_B: begin
								scl = 1'b0;
								enter(i2cme_pkg::PH_IDLE);
								fin = 1'b1;
							end
							i2cme_pkg::PH_SP_A: begin
								scl = 1'b1;
								enter(i2cme_pkg::PH_SP_B);
							end
							i2cme_pkg::PH_SP_C: begin
								enter(i2cme_pkg::PH_IDLE);
								fin = 1'b1;
							end
							i2cme_pkg::PH_W_SET: begin
								scl = 1'b1;
								enter(i2cme_pkg::PH_W_HI);
							end
							i2cme_pkg::PH_W_HI: begin
								scl = 1'b0;
								enter(i2cme_pkg::PH_W_LO);
							end
							i2cme_pkg::PH_W_LO: begin
								bit_index = bit_index + 4'd1;
								if (bit_index < 4'd8) begin
									shift_byte = {shift_byte[6:0], 1'b0};
									sda = shift_byte[7];
									enter(i2cme_pkg::PH_W_SET);
								end else begin
									sda = 1'b1;
									enter(i2cme_pkg::PH_K_REL);
								end
							end
							i2cme_pkg::PH_K_REL: begin
								scl = 1'b1;
								enter(i2cme_pkg::PH_K_RISE);
							end
							i2cme_pkg::PH_K_RISE: begin
								poll_count = '0;
								enter(i2cme_pkg::PH_K_POLL);
							end
							i2cme_pkg::PH_R_LO: begin
								scl = 1'b1;
								enter(i2cme_pkg::PH_R_HI);
							end
							i2cme_pkg::PH_R_HI: begin
								shift_byte = {shift_byte[6:0], t.sda_in};
								scl = 1'b0;
								bit_index = bit_index + 4'd1;
								if (bit_index < 4'd8) begin
									enter(i2cme_pkg::PH_R_LO);
								end else begin
									rx_hold = shift_byte;
									sda = ~ack_choice;
									enter(i2cme_pkg::PH_A_SET);
								end
							end
							i2cme_pkg::PH_A_SET: begin
								scl = 1'b1;
								enter(i2cme_pkg::PH_A_HI);
							end
							i2cme_pkg::PH_A_HI: begin
								scl = 1'b0;
								enter(i2cme_pkg::PH_IDLE);
								fin = 1'b1;
							end
							default: begin
								enter(i2cme_pkg::PH_IDLE);
							end
						endcase
					end
				end
			endcase
			r.scl_level = scl;
			r.sda_level = sda;
			r.busy_res = (phase != i2cme_pkg::PH_IDLE);
			r.done_res = fin;
			r.rx_byte = rx_hold;
			r.ack_failed = fail_flag;
			expected_q.push_back(r);
		endfunction

		// Compare one result word with the oldest prediction; empty string if it matches
		function string check_result(logic [15:0] word);
			i2cme_pkg::result_t got;
			i2cme_pkg::result_t exp_r;
			string              msg;
			got.scl_level = word[0];
			got.sda_level = word[1];
			got.busy_res = word[2];
			got.done_res = word[3];
			got.rx_byte = word[11:4];
			got.ack_failed = word[12];
			if (expected_q.size() == 0)
				return $sformatf("result word %h arrived with nothing pending", word);
			exp_r = expected_q.pop_front();
			msg = "";
			if (got.scl_level !== exp_r.scl_level)
				msg = {msg, $sformatf(" scl %b/%b", got.scl_level, exp_r.scl_level)};
			if (got.sda_level !== exp_r.sda_level)
				msg = {msg, $sformatf(" sda %b/%b", got.sda_level, exp_r.sda_level)};
			if (got.busy_res !== exp_r.busy_res)
				msg = {msg, $sformatf(" busy %b/%b", got.busy_res, exp_r.busy_res)};
			if (got.done_res !== exp_r.done_res)
				msg = {msg, $sformatf(" done %b/%b", got.done_res, exp_r.done_res)};
			if (got.rx_byte !== exp_r.rx_byte)
				msg = {msg, $sformatf(" rx %h/%h", got.rx_byte, exp_r.rx_byte)};
			if (got.ack_failed !== exp_r.ack_failed)
				msg = {msg, $sformatf(" ack_failed %b/%b", got.ack_failed, exp_r.ack_failed)};
			if (msg != "")
				msg = $sformatf("result %0d got/expected:%s", checked, msg);
			checked++;
			return msg;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	i2c_tick_scoreboard sb;
	int         error_count  = 0;
	int         results_seen = 0;
	int         idle_cycles  = 0;
	int         ticks_sent   = 0;
	int         burst_left   = 0;
	int         ack_plan     = ACK_NOW;
	logic [7:0] rx_pattern   = 8'h00;

	i2c_master_byte_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH %s", msg);
		error_count++;
	endtask

	// Build a tick with no command; the SDA level follows the bus plan of the phase
	function automatic tick_t filler_tick();
		tick_t t;
		t.cmd_valid = 1'b0;
		t.opcode = 2'($urandom_range(0, 3));
		t.tx_byte = 8'($urandom);
		t.send_ack = 1'($urandom_range(0, 1));
		t.sda_in = 1'($urandom_range(0, 1));
		if (sb.phase == i2cme_pkg::PH_K_POLL) begin
			case (ack_plan)
				ACK_NOW:   t.sda_in = 1'b0;
				ACK_NEVER: t.sda_in = 1'b1;
				default:   t.sda_in = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
			endcase
		end else if (sb.phase == i2cme_pkg::PH_R_HI) begin
			t.sda_in = rx_pattern[3'(7 - sb.bit_index)];
		end
		return t;
	endfunction

	// Offer one tick in bursts with random gaps; return at the next falling edge
	task automatic send_tick(input tick_t t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tdata <= {5'd0, t.sda_in, t.send_ack, t.tx_byte, t.cmd_valid};
		s_axis_tuser <= t.opcode;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_tick(t);
		ticks_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic idle_ticks(input int count);
		repeat (count) send_tick(filler_tick());
	endtask

	// Issue one command and feed ticks until the model is idle again
	task automatic run_cmd(input logic [1:0] op, input logic [7:0] txb, input logic ack,
			input bit noise);
		tick_t t;
		t = filler_tick();
		t.cmd_valid = 1'b1;
		t.opcode = op;
		t.tx_byte = txb;
		t.send_ack = ack;
		send_tick(t);
		while (sb.phase != i2cme_pkg::PH_IDLE) begin
			t = filler_tick();
			// offer commands that a busy engine has to drop
			if (noise && $urandom_range(0, 3) == 0)
				t.cmd_valid = 1'b1;
			send_tick(t);
		end
	endtask

	// Stop the input, wait for every pending result, then let the pipeline settle
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write both registers back to back
	task automatic set_regs(input logic [15:0] unit_len, input logic [7:0] poll_lim);
		cfg_valid <= 1'b1;
		cfg_index <= i2cme_pkg::CFG_UNIT_TICKS;
		cfg_data <= unit_len;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(i2cme_pkg::CFG_UNIT_TICKS, unit_len);
		@(negedge clk);
		cfg_index <= i2cme_pkg::CFG_ACK_POLL;
		cfg_data <= {8'd0, poll_lim};
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(i2cme_pkg::CFG_ACK_POLL, {8'd0, poll_lim});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Check each result transaction; end the run when nothing moves for too long
	always @(posedge clk) begin : result_monitor
		string msg;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				msg = sb.check_result(m_axis_tdata);
				if (msg != "")
					report_mismatch(msg);
				results_seen++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	// Result side: stall patterns that change periodically, plus one long hold
	initial begin : result_sink
		int   cyc;
		int   stall_mode;
		int   hold_left;
		bit   hold_done;
		logic ready;
		cyc = 0;
		stall_mode = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 64 == 0)
				stall_mode = $urandom_range(0, 2);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				ready = 1'b0;
			end else begin
				case (stall_mode)
					0:       ready = 1'b1;
					1:       ready = ($urandom_range(0, 9) > 2);
					default: ready = (cyc % 5 != 0);
				endcase
			end
			m_axis_tready <= ready;
		end
	end

	initial begin : stimulus
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset line levels, then one start at the reset timing
		ack_plan = ACK_NOW;
		idle_ticks(3);
		run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 1'b0);
		quiesce();

		// longest unit and poll limit: idle ticks only, any command would outlast the run
		set_regs(16'hFFFF, 8'd255);
		idle_ticks(4);
		quiesce();

		// each command at the shortest unit, byte extremes, ACK and NACK
		set_regs(16'd1, 8'd2);
		run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 1'b0);
		ack_plan = ACK_NOW;
		run_cmd(i2cme_pkg::OP_WRITE, 8'hFF, 1'b0, 1'b0);
		ack_plan = ACK_LATER;
		run_cmd(i2cme_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0);
		ack_plan = ACK_NEVER;
		run_cmd(i2cme_pkg::OP_WRITE, 8'hA5, 1'b0, 1'b0);
		rx_pattern = 8'hFF;
		run_cmd(i2cme_pkg::OP_READ, 8'h00, 1'b1, 1'b0);
		rx_pattern = 8'h00;
		run_cmd(i2cme_pkg::OP_READ, 8'hFF, 1'b0, 1'b0);
		rx_pattern = 8'h5A;
		run_cmd(i2cme_pkg::OP_READ, 8'h3C, 1'b1, 1'b1);
		run_cmd(i2cme_pkg::OP_STOP, 8'h00, 1'b0, 1'b1);
		idle_ticks(3);
		quiesce();

		// zero unit length and zero poll limit
		set_regs(16'd0, 8'd0);
		ack_plan = ACK_NEVER;
		run_cmd(i2cme_pkg::OP_WRITE, 8'h3C, 1'b0, 1'b0);
		ack_plan = ACK_NOW;
		run_cmd(i2cme_pkg::OP_WRITE, 8'hC3, 1'b1, 1'b1);
		run_cmd(i2cme_pkg::OP_START, 8'h00, 1'b0, 1'b0);
		run_cmd(i2cme_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		quiesce();

		// random command streams, one setting per pass
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			int pass_end;
			case (p)
				0:       set_regs(16'd1, 8'd3);
				1:       set_regs(16'd0, 8'd0);
				2:       set_regs(16'd2, 8'd255);
				3:       set_regs(16'd3, 8'($urandom_range(0, 15)));
				default: set_regs(16'($urandom_range(1, 2)), 8'($urandom_range(1, 8)));
			endcase
			pass_end = ticks_sent + RANDOM_TICKS / RANDOM_PHASES;
			while (ticks_sent < pass_end) begin
				if ($urandom_range(0, 5) == 0) begin
					idle_ticks($urandom_range(1, 3));
				end else begin
					case ($urandom_range(0, 4))
						0:       ack_plan = ACK_NEVER;
						1, 2:    ack_plan = ACK_NOW;
						default: ack_plan = ACK_LATER;
					endcase
					rx_pattern = 8'($urandom);
					run_cmd(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
						1'b1);
				end
			end
			quiesce();
		end

		$display("Covered %0d ticks, %0d results checked; start %0d, stop %0d",
			ticks_sent, sb.checked, sb.cmd_count[i2cme_pkg::OP_START],
			sb.cmd_count[i2cme_pkg::OP_STOP]);
		$display("Write %0d, read %0d, busy commands dropped %0d, acknowledge timeouts %0d",
			sb.cmd_count[i2cme_pkg::OP_WRITE], sb.cmd_count[i2cme_pkg::OP_READ],
			sb.ignored, sb.timeouts);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
rtl/i2cme_pkg.sv
rtl/i2cme_front.sv
rtl/i2cme_queue.sv
rtl/i2cme_back.sv
rtl/i2c_master_byte_engine.sv
verif/tb.sv
